// ===== src/framebuffer_pixel_writer_macros.svh =====
// ----------------------------------------------------------------------------
// Frame buffer pixel writer assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef FRAMEBUFFER_PIXEL_WRITER_MACROS_SVH
`define FRAMEBUFFER_PIXEL_WRITER_MACROS_SVH

// same-cycle implication
`define FBPW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FBPW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/fbpw_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame buffer pixel writer package
// Sizes, operation and register codes, and controller/datapath links.
// ----------------------------------------------------------------------------
package fbpw_pkg;

    localparam int FB_BYTES   = 16384;
    localparam int MAX_DIM    = 512;
    localparam int ADDR_W     = $clog2(FB_BYTES);
    localparam int DIM_W      = 10;
    localparam int COORD_W    = 9;
    localparam int BADDR_W    = 14;
    localparam int PIX_ADDR_W = 18;
    localparam int CFG_IDX_W  = 3;

    // operation codes on s_func
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LWIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LHEIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MWIDTH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MHEIGHT  = 3'd6;

    // rotation codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    typedef struct packed {
        logic load_in;   // capture the accepted beat
        logic do_map;    // rotate, mirror and bound-check
        logic do_addr;   // form the byte address
        logic rd_en;     // fetch addr_reg
        logic wr_merge;  // write back the modified byte
        logic clr_wr;    // write one byte of the clear sweep
        logic load_out;  // load the result register
    } fbpw_cmd_t;

    typedef struct packed {
        logic ok;        // item still live (in bounds, in store)
        logic is_read;
        logic clr_last;
    } fbpw_sts_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
    endfunction

endpackage

// ===== src/fbpw_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fbpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/fbpw_ctrl.sv =====
// ----------------------------------------------------------------------------
// Frame buffer pixel writer controller
// Sequences write, read and clear items and owns the result valid flag.
// ----------------------------------------------------------------------------
module fbpw_ctrl import fbpw_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    output logic       m_valid,
    input  logic       m_ready,
    output fbpw_cmd_t  cmd,
    input  fbpw_sts_t  sts
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAP   = 3'd1;
    localparam logic [2:0] ST_ADDR  = 3'd2;
    localparam logic [2:0] ST_FETCH = 3'd3;
    localparam logic [2:0] ST_MERGE = 3'd4;
    localparam logic [2:0] ST_RDATA = 3'd5;
    localparam logic [2:0] ST_CLEAR = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    priority if (s_func == FUNC_WRITE) begin
                        state_next = ST_MAP;
                    end else if (s_func == FUNC_READ) begin
                        state_next = ST_FETCH;
                    end else if (s_func == FUNC_CLEAR) begin
                        state_next = ST_CLEAR;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MAP: begin
                cmd.do_map = 1'b1;
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                cmd.do_addr = 1'b1;
                state_next  = ST_FETCH;
            end
            ST_FETCH: begin
                cmd.rd_en = sts.ok;
                priority if (sts.is_read) begin
                    state_next = ST_RDATA;
                end else if (sts.ok) begin
                    state_next = ST_MERGE;
                end else begin
                    // dropped write
                    state_next = ST_IDLE;
                end
            end
            ST_MERGE: begin
                cmd.wr_merge = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_RDATA: begin
                // hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== src/fbpw_datapath.sv =====
// ----------------------------------------------------------------------------
// Frame buffer pixel writer datapath
// Registers, coordinate mapping, address forming, byte merge and frame RAM.
// ----------------------------------------------------------------------------
module fbpw_datapath import fbpw_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic [1:0]           s_func,
    input  logic [COORD_W-1:0]   s_pos_x,
    input  logic [COORD_W-1:0]   s_pos_y,
    input  logic [1:0]           s_pixel_color,
    input  logic [BADDR_W-1:0]   s_byte_address,
    output logic [7:0]           m_read_data,
    input  fbpw_cmd_t            cmd,
    output fbpw_sts_t            sts
);

    // configuration
    logic [1:0]       rot_reg, mirror_reg;
    logic             depth_reg;
    logic [DIM_W-1:0] lw_reg, lh_reg, mw_reg, mh_reg;

    // item state
    logic [1:0]         func_reg, color_reg;
    logic [COORD_W-1:0] px_reg, py_reg, x_reg, y_reg;
    logic               ok_reg, ok_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [ADDR_W-1:0]  clr_cnt_reg;
    logic [7:0]         out_reg;

    logic [DIM_W-1:0]     lw, lh, mw, mh;
    logic signed [11:0]   lx, ly, mw_s, mh_s, xr, yr, xm, ym;
    logic                 map_ok;
    logic [7:0]           row_bytes;
    logic [6:0]           col_byte;
    logic [16:0]          row_off;
    logic [PIX_ADDR_W-1:0] pix_addr;
    logic [7:0]           rd_data, merged, clr_pat, mask2, val2, mask1;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [7:0]           wr_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_reg    <= ROT_0;
            mirror_reg <= 2'd0;
            depth_reg  <= 1'b0;
            lw_reg     <= DIM_W'(128);
            lh_reg     <= DIM_W'(296);
            mw_reg     <= DIM_W'(128);
            mh_reg     <= DIM_W'(296);
        end else if (cfg_wr) begin
            unique case (cfg_index)
                CFG_ROTATION: rot_reg    <= cfg_data[1:0];
                CFG_MIRROR:   mirror_reg <= cfg_data[1:0];
                CFG_DEPTH:    depth_reg  <= cfg_data[0];
                CFG_LWIDTH:   lw_reg     <= cfg_data;
                CFG_LHEIGHT:  lh_reg     <= cfg_data;
                CFG_MWIDTH:   mw_reg     <= cfg_data;
                CFG_MHEIGHT:  mh_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // rotate, then mirror, then check against the logical canvas and the stored frame
    always_comb begin
        lw   = clamp_dim(lw_reg);
        lh   = clamp_dim(lh_reg);
        mw   = clamp_dim(mw_reg);
        mh   = clamp_dim(mh_reg);
        lx   = $signed({3'b000, px_reg});
        ly   = $signed({3'b000, py_reg});
        mw_s = $signed({2'b00, mw});
        mh_s = $signed({2'b00, mh});
        unique case (rot_reg)
            ROT_0: begin
                xr = lx;
                yr = ly;
            end
            ROT_90: begin
                xr = mw_s - ly - 12'sd1;
                yr = lx;
            end
            ROT_180: begin
                xr = mw_s - lx - 12'sd1;
                yr = mh_s - ly - 12'sd1;
            end
            ROT_270: begin
                xr = ly;
                yr = mh_s - lx - 12'sd1;
            end
            default: begin
                xr = lx;
                yr = ly;
            end
        endcase
        xm = mirror_reg[0] ? (mw_s - xr - 12'sd1) : xr;
        ym = mirror_reg[1] ? (mh_s - yr - 12'sd1) : yr;
        map_ok = ({1'b0, px_reg} < lw) && ({1'b0, py_reg} < lh)
                 && !xm[11] && (xm < mw_s) && !ym[11] && (ym < mh_s);
    end

    // byte address of the mapped pixel
    always_comb begin
        if (depth_reg) begin
            row_bytes = 8'(({1'b0, mw} + 11'd3) >> 2);
            col_byte  = 7'(x_reg >> 2);
        end else begin
            row_bytes = 8'(({1'b0, mw} + 11'd7) >> 3);
            col_byte  = 7'(x_reg >> 3);
        end
        row_off  = 17'(y_reg) * 17'(row_bytes);
        pix_addr = PIX_ADDR_W'(row_off) + PIX_ADDR_W'(col_byte);
    end

    always_comb begin
        ok_next   = ok_reg;
        addr_next = addr_reg;
        if (cmd.load_in) begin
            ok_next   = 32'(s_byte_address) < 32'(FB_BYTES);
            addr_next = ADDR_W'(s_byte_address);
        end else if (cmd.do_map) begin
            ok_next = map_ok;
        end else if (cmd.do_addr) begin
            ok_next   = ok_reg && (pix_addr < PIX_ADDR_W'(FB_BYTES));
            addr_next = ADDR_W'(pix_addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ok_reg <= 1'b0;
        end else begin
            ok_reg <= ok_next;
        end
        addr_reg <= addr_next;
        if (cmd.load_in) begin
            func_reg    <= s_func;
            px_reg      <= s_pos_x;
            py_reg      <= s_pos_y;
            color_reg   <= s_pixel_color;
            clr_cnt_reg <= '0;
        end else if (cmd.clr_wr) begin
            clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
        end
        if (cmd.do_map) begin
            x_reg <= xm[COORD_W-1:0];
            y_reg <= ym[COORD_W-1:0];
        end
        if (cmd.load_out) begin
            out_reg <= ok_reg ? rd_data : 8'h00;
        end
    end

    // read-modify-write of the fetched byte, and the clear fill pattern
    always_comb begin
        mask2 = 8'hC0 >> {x_reg[1:0], 1'b0};
        val2  = {color_reg, 6'b000000} >> {x_reg[1:0], 1'b0};
        mask1 = 8'h80 >> x_reg[2:0];
        if (depth_reg) begin
            merged  = (rd_data & ~mask2) | val2;
            clr_pat = {4{color_reg}};
        end else begin
            merged  = color_reg[0] ? (rd_data | mask1) : (rd_data & ~mask1);
            clr_pat = color_reg[0] ? 8'hFF : 8'h00;
        end
    end

    assign wr_en   = cmd.wr_merge || cmd.clr_wr;
    assign wr_addr = cmd.clr_wr ? clr_cnt_reg : addr_reg;
    assign wr_data = cmd.clr_wr ? clr_pat : merged;

    fbpw_ram #(
        .WIDTH(8),
        .DEPTH(FB_BYTES)
    ) u_frame_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (cmd.rd_en),
        .rd_addr(addr_reg),
        .rd_data(rd_data)
    );

    assign sts.ok       = ok_reg;
    assign sts.is_read  = (func_reg == FUNC_READ);
    assign sts.clr_last = (clr_cnt_reg == ADDR_W'(FB_BYTES - 1));
    assign m_read_data  = out_reg;

endmodule

// ===== src/framebuffer_pixel_writer.sv =====
// Rotated, mirrored, packed frame store. A pixel write passes through capture,
// map, address, fetch and merge before the next accept, since each write is a
// read-modify-write through the single write and read port of the frame RAM. A
// write that is dropped by a bounds check skips the merge. An unused function
// code returns straight to idle. A byte read passes through capture, fetch and
// result load, and its result sits in an output register, so the next item is
// taken while the byte waits on m_ready. A second read stalls in its result
// state until that register is free. A clear sweeps the RAM one byte per cycle
// and blocks input until every one of the FB_BYTES bytes has been written.
// The store is not cleared after reset.
// Configuration writes are taken in any cycle and must only come while idle.
// ----------------------------------------------------------------------------
// Frame buffer pixel writer
// Top level: handshakes, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
`include "framebuffer_pixel_writer_macros.svh"

module framebuffer_pixel_writer import fbpw_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_func,
    input  logic [COORD_W-1:0]   s_pos_x,
    input  logic [COORD_W-1:0]   s_pos_y,
    input  logic [1:0]           s_pixel_color,
    input  logic [BADDR_W-1:0]   s_byte_address,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_read_data
);

    fbpw_cmd_t cmd;
    fbpw_sts_t sts;

    assign cfg_ready = 1'b1;

    fbpw_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_func (s_func),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .cmd    (cmd),
        .sts    (sts)
    );

    fbpw_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_func        (s_func),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_pixel_color (s_pixel_color),
        .s_byte_address(s_byte_address),
        .m_read_data   (m_read_data),
        .cmd           (cmd),
        .sts           (sts)
    );

    `FBPW_ASSERT_NOW(a_clear_blocks_input, cmd.clr_wr, !s_ready, "beat taken during clear")
    `FBPW_ASSERT_NEXT(a_clear_holds_off, s_valid && s_ready && s_func == FUNC_CLEAR, !s_ready, "clear did not start")
    `FBPW_ASSERT_NOW(a_merge_only_live, cmd.wr_merge, sts.ok && !sts.is_read, "dropped write reached RAM")
    `FBPW_ASSERT_NEXT(a_result_loaded, cmd.load_out, m_valid, "read result lost")

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame buffer pixel writer testbench
// Drives pixel writes, byte reads and clears through the input channel under
// many rotation, mirror, depth and size settings. A shadow copy of the frame
// store predicts every read byte, and a checker compares each result beat in
// order. The sender idles in bursts, and the receiver stalls on its own.
// ----------------------------------------------------------------------------
module testbench;
    import fbpw_pkg::*;

    localparam logic [1:0] FUNC_NOP     = 2'd3;
    localparam logic [1:0] MIRROR_OFF   = 2'd0;
    localparam logic [1:0] MIRROR_H     = 2'd1;
    localparam logic [1:0] MIRROR_V     = 2'd2;
    localparam logic [1:0] MIRROR_BOTH  = 2'd3;
    localparam logic       DEPTH_1BPP   = 1'b0;
    localparam logic       DEPTH_2BPP   = 1'b1;

    localparam int STALL_NONE     = 0;
    localparam int STALL_RANDOM   = 1;
    localparam int STALL_PATTERN  = 2;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int LIMIT_CYCLES   = 2000000;
    localparam int SETTLE_CYCLES  = 16;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [1:0]           s_func;
    logic [COORD_W-1:0]   s_pos_x;
    logic [COORD_W-1:0]   s_pos_y;
    logic [1:0]           s_pixel_color;
    logic [BADDR_W-1:0]   s_byte_address;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [7:0]           m_read_data;

    // shadow of the block's registers and frame store
    logic [1:0]       rotation_cfg;
    logic [1:0]       mirror_cfg;
    logic             depth_cfg;
    logic [DIM_W-1:0] lwidth_cfg;
    logic [DIM_W-1:0] lheight_cfg;
    logic [DIM_W-1:0] mwidth_cfg;
    logic [DIM_W-1:0] mheight_cfg;
    logic [7:0]       frame_model [FB_BYTES];

    logic [7:0] expected_bytes [$];
    int         touched_addr [$];
    logic [7:0] want_byte;

    int error_count     = 0;
    int cycle_count     = 0;
    int settle_cycles   = SETTLE_CYCLES;
    int clears_left     = 6;
    int burst_left      = 0;
    bit gaps_on         = 1'b0;
    int stall_style     = STALL_NONE;
    int holdoff_trigger = 0;
    int holdoff_seen    = 0;
    int hold_count      = 0;

    framebuffer_pixel_writer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_pixel_color  (s_pixel_color),
        .s_byte_address (s_byte_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_data    (m_read_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: a long hold-off on request, otherwise the current stall style
    always @(negedge aclk) begin
        if (holdoff_trigger != holdoff_seen) begin
            holdoff_seen = holdoff_trigger;
            hold_count   = HOLDOFF_CYCLES;
        end
        if (hold_count > 0) begin
            hold_count--;
            m_ready <= 1'b0;
        end else begin
            case (stall_style)
                STALL_NONE:   m_ready <= 1'b1;
                STALL_RANDOM: m_ready <= ($urandom_range(0, 99) >= 30);
                default:      m_ready <= ((cycle_count % 7) >= 3);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: read beat with none expected, expected none actual %02h",
                         $time, m_read_data);
                error_count++;
            end else begin
                want_byte = expected_bytes.pop_front();
                if (m_read_data !== want_byte) begin
                    $display("%0t: read_data mismatch, expected %02h actual %02h",
                             $time, want_byte, m_read_data);
                    error_count++;
                end
            end
        end
    end

    function automatic int saturate_dim(input logic [DIM_W-1:0] v);
        return (v > DIM_W'(MAX_DIM)) ? MAX_DIM : int'(v);
    endfunction

    function automatic void predict_pixel_write(input logic [8:0] px,
                                                input logic [8:0] py,
                                                input logic [1:0] color);
        int lw, lh, mw, mh, lx, ly, mx, my, row_bytes, addr, shift;
        logic [7:0] mask;
        lw = saturate_dim(lwidth_cfg);
        lh = saturate_dim(lheight_cfg);
        mw = saturate_dim(mwidth_cfg);
        mh = saturate_dim(mheight_cfg);
        lx = int'(px);
        ly = int'(py);
        if (lx >= lw || ly >= lh)
            return;
        case (rotation_cfg)
            ROT_0: begin
                mx = lx;
                my = ly;
            end
            ROT_90: begin
                mx = mw - ly - 1;
                my = lx;
            end
            ROT_180: begin
                mx = mw - lx - 1;
                my = mh - ly - 1;
            end
            default: begin
                mx = ly;
                my = mh - lx - 1;
            end
        endcase
        if (mirror_cfg == MIRROR_H || mirror_cfg == MIRROR_BOTH)
            mx = mw - mx - 1;
        if (mirror_cfg == MIRROR_V || mirror_cfg == MIRROR_BOTH)
            my = mh - my - 1;
        if (mx < 0 || my < 0 || mx >= mw || my >= mh)
            return;
        if (depth_cfg == DEPTH_2BPP) begin
            shift     = (mx % 4) * 2;
            row_bytes = (mw + 3) / 4;
            addr      = mx / 4 + my * row_bytes;
            if (addr >= FB_BYTES)
                return;
            mask = 8'hC0 >> shift;
            frame_model[addr] = (frame_model[addr] & ~mask) | ({color, 6'b0} >> shift);
        end else begin
            row_bytes = (mw + 7) / 8;
            addr      = mx / 8 + my * row_bytes;
            if (addr >= FB_BYTES)
                return;
            mask = 8'h80 >> (mx % 8);
            if (color[0])
                frame_model[addr] = frame_model[addr] | mask;
            else
                frame_model[addr] = frame_model[addr] & ~mask;
        end
        touched_addr.push_back(addr);
        if (touched_addr.size() > 48)
            void'(touched_addr.pop_front());
    endfunction

    function automatic void fill_model(input logic [1:0] color);
        logic [7:0] pattern;
        if (depth_cfg == DEPTH_2BPP)
            pattern = {4{color}};
        else
            pattern = color[0] ? 8'hFF : 8'h00;
        foreach (frame_model[i])
            frame_model[i] = pattern;
    endfunction

    task automatic offer_item(input logic [1:0] func, input logic [8:0] px,
                              input logic [8:0] py, input logic [1:0] color,
                              input logic [13:0] baddr);
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_func         <= func;
        s_pos_x        <= px;
        s_pos_y        <= py;
        s_pixel_color  <= color;
        s_byte_address <= baddr;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        case (func)
            FUNC_WRITE: predict_pixel_write(px, py, color);
            FUNC_READ:  expected_bytes.push_back(frame_model[baddr]);
            FUNC_CLEAR: fill_model(color);
            default:    ;
        endcase
        settle_cycles = (func == FUNC_CLEAR) ? FB_BYTES + SETTLE_CYCLES : SETTLE_CYCLES;
    endtask

    task automatic pace_sender();
        int gap;
        if (!gaps_on)
            return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        gap = $urandom_range(1, 10);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (gap - 1)
            @(negedge aclk);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(0, 8);
    endtask

    // drop valid, drain all read beats, then let any write or clear finish
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge aclk);
        repeat (settle_cycles)
            @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [DIM_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            CFG_ROTATION: rotation_cfg = data[1:0];
            CFG_MIRROR:   mirror_cfg   = data[1:0];
            CFG_DEPTH:    depth_cfg    = data[0];
            CFG_LWIDTH:   lwidth_cfg   = data;
            CFG_LHEIGHT:  lheight_cfg  = data;
            CFG_MWIDTH:   mwidth_cfg   = data;
            CFG_MHEIGHT:  mheight_cfg  = data;
            default:      ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input logic [1:0] rot, input logic [1:0] mir,
                                input logic depth, input logic [DIM_W-1:0] lw,
                                input logic [DIM_W-1:0] lh,
                                input logic [DIM_W-1:0] mw,
                                input logic [DIM_W-1:0] mh);
        wait_idle();
        cfg_write(CFG_ROTATION, DIM_W'(rot));
        cfg_write(CFG_MIRROR, DIM_W'(mir));
        cfg_write(CFG_DEPTH, DIM_W'(depth));
        cfg_write(CFG_LWIDTH, lw);
        cfg_write(CFG_LHEIGHT, lh);
        cfg_write(CFG_MWIDTH, mw);
        cfg_write(CFG_MHEIGHT, mh);
    endtask

    // mostly in-bounds writes and reads of recently touched bytes, some noise
    task automatic offer_random(output bit counted);
        int r, lw, lh;
        logic [1:0]  func;
        logic [8:0]  px, py;
        logic [1:0]  color;
        logic [13:0] baddr;
        r       = $urandom_range(0, 99);
        lw      = saturate_dim(lwidth_cfg);
        lh      = saturate_dim(lheight_cfg);
        px      = 9'($urandom_range(0, 511));
        py      = 9'($urandom_range(0, 511));
        color   = 2'($urandom_range(0, 3));
        baddr   = 14'($urandom_range(0, FB_BYTES - 1));
        counted = 1'b1;
        if (r < 55) begin
            func = FUNC_WRITE;
            if ($urandom_range(0, 9) != 0 && lw > 0 && lh > 0) begin
                px = 9'($urandom_range(0, lw - 1));
                py = 9'($urandom_range(0, lh - 1));
            end
        end else if (r < 93) begin
            func = FUNC_READ;
            if (touched_addr.size() > 0 && $urandom_range(0, 9) < 6)
                baddr = 14'(touched_addr[$urandom_range(0, touched_addr.size() - 1)]);
        end else if (r < 99 || clears_left == 0) begin
            func    = FUNC_NOP;
            counted = 1'b0;
        end else begin
            func = FUNC_CLEAR;
            clears_left--;
        end
        offer_item(func, px, py, color, baddr);
        pace_sender();
    endtask

    task automatic run_random(input int count);
        int done;
        bit counted;
        done = 0;
        while (done < count) begin
            offer_random(counted);
            if (counted)
                done++;
        end
    endtask

    task automatic test_clear_fill();
        offer_item(FUNC_CLEAR, 9'd0, 9'd0, 2'd1, 14'd0);
        offer_item(FUNC_READ, 9'h1FF, 9'h1FF, 2'd3, 14'd0);
        offer_item(FUNC_READ, 9'd0, 9'd0, 2'd0, 14'h3FFF);
        wait_idle();
        cfg_write(CFG_DEPTH, DIM_W'(DEPTH_2BPP));
        offer_item(FUNC_CLEAR, 9'd0, 9'd0, 2'd1, 14'd0);
        offer_item(FUNC_READ, 9'd0, 9'd0, 2'd0, 14'd8191);
        wait_idle();
        cfg_write(CFG_DEPTH, DIM_W'(DEPTH_1BPP));
        // bit 1 alone must not set the fill at one bit per pixel
        offer_item(FUNC_CLEAR, 9'd0, 9'd0, 2'd2, 14'd0);
        offer_item(FUNC_READ, 9'd0, 9'd0, 2'd0, 14'd100);
    endtask

    task automatic test_directed_writes();
        offer_item(FUNC_WRITE, 9'd0, 9'd0, 2'd1, 14'd0);
        offer_item(FUNC_READ, 9'd0, 9'd0, 2'd0, 14'd0);
        offer_item(FUNC_WRITE, 9'd127, 9'd295, 2'd1, 14'd0);
        offer_item(FUNC_READ, 9'd0, 9'd0, 2'd0, 14'd4735);
        // just past each logical bound, and the field extremes
        offer_item(FUNC_WRITE, 9'd128, 9'd0, 2'd1, 14'd0);
        offer_item(FUNC_WRITE, 9'd0, 9'd296, 2'd1, 14'd0);
        offer_item(FUNC_WRITE, 9'd511, 9'd511, 2'd3, 14'h3FFF);
        offer_item(FUNC_READ, 9'd0, 9'd0, 2'd0, 14'd16);
        offer_item(FUNC_READ, 9'd0, 9'd0, 2'd0, 14'd4736);
        offer_item(FUNC_WRITE, 9'd7, 9'd0, 2'd1, 14'd0);
        offer_item(FUNC_WRITE, 9'd0, 9'd0, 2'd0, 14'd0);
        offer_item(FUNC_READ, 9'd0, 9'd0, 2'd0, 14'd0);
        offer_item(FUNC_NOP, 9'h1FF, 9'h1FF, 2'd3, 14'h3FFF);
        offer_item(FUNC_READ, 9'd0, 9'd0, 2'd0, 14'h3FFF);
        wait_idle();
        cfg_write(CFG_DEPTH, DIM_W'(DEPTH_2BPP));
        offer_item(FUNC_WRITE, 9'd3, 9'd0, 2'd2, 14'd0);
        offer_item(FUNC_READ, 9'd0, 9'd0, 2'd0, 14'd0);
    endtask

    task automatic test_rotation_mirror();
        int mw, mh;
        for (int rot = 0; rot < 4; rot++) begin
            for (int mir = 0; mir < 4; mir++) begin
                mw = $urandom_range(8, 160);
                mh = $urandom_range(8, 100);
                // swap the logical canvas for the quarter turns
                if (rot == ROT_90 || rot == ROT_270)
                    set_geometry(rot[1:0], mir[1:0], 1'($urandom_range(0, 1)),
                                 DIM_W'(mh), DIM_W'(mw), DIM_W'(mw), DIM_W'(mh));
                else
                    set_geometry(rot[1:0], mir[1:0], 1'($urandom_range(0, 1)),
                                 DIM_W'(mw), DIM_W'(mh), DIM_W'(mw), DIM_W'(mh));
                stall_style = $urandom_range(STALL_NONE, STALL_PATTERN);
                gaps_on     = 1'b1;
                run_random(70);
            end
        end
    endtask

    task automatic test_dimension_limits();
        set_geometry(ROT_0, MIRROR_OFF, DEPTH_1BPP, 10'd1, 10'd1, 10'd1, 10'd1);
        run_random(70);
        // rows past 127 land beyond the store at two bits per pixel
        set_geometry(ROT_0, MIRROR_OFF, DEPTH_2BPP, 10'd512, 10'd512, 10'd512, 10'd512);
        run_random(70);
        set_geometry(ROT_180, MIRROR_BOTH, DEPTH_1BPP,
                     10'd1023, 10'd1023, 10'd1023, 10'd1023);
        stall_style = STALL_RANDOM;
        run_random(70);
        // logical canvas larger than memory, so mapped coordinates go negative
        set_geometry(ROT_90, MIRROR_H, DEPTH_1BPP, 10'd512, 10'd512, 10'd64, 10'd32);
        run_random(70);
        set_geometry(ROT_270, MIRROR_V, DEPTH_2BPP, 10'd300, 10'd200, 10'd1, 10'd1);
        stall_style = STALL_PATTERN;
        run_random(70);
        set_geometry(ROT_0, MIRROR_OFF, DEPTH_1BPP, 10'd0, 10'd296, 10'd128, 10'd296);
        run_random(70);
        set_geometry(ROT_0, MIRROR_OFF, DEPTH_2BPP, 10'd128, 10'd296, 10'd0, 10'd296);
        run_random(70);
        repeat (2) begin
            set_geometry(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                         1'($urandom_range(0, 1)), DIM_W'($urandom_range(0, 1023)),
                         DIM_W'($urandom_range(0, 1023)), DIM_W'($urandom_range(0, 1023)),
                         DIM_W'($urandom_range(0, 1023)));
            stall_style = $urandom_range(STALL_NONE, STALL_PATTERN);
            run_random(70);
        end
    endtask

    task automatic test_output_backpressure();
        set_geometry(ROT_0, MIRROR_OFF, DEPTH_1BPP, 10'd128, 10'd296, 10'd128, 10'd296);
        stall_style = STALL_NONE;
        gaps_on     = 1'b0;
        run_random(20);
        // hold the result side while reads keep coming, so input backs up
        holdoff_trigger++;
        repeat (40)
            offer_item(FUNC_READ, 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                       2'($urandom_range(0, 3)), 14'($urandom_range(0, FB_BYTES - 1)));
        gaps_on     = 1'b1;
        stall_style = STALL_RANDOM;
        run_random(40);
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_ROTATION;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_func         = FUNC_WRITE;
        s_pos_x        = '0;
        s_pos_y        = '0;
        s_pixel_color  = '0;
        s_byte_address = '0;
        rotation_cfg   = ROT_0;
        mirror_cfg     = MIRROR_OFF;
        depth_cfg      = DEPTH_1BPP;
        lwidth_cfg     = 10'd128;
        lheight_cfg    = 10'd296;
        mwidth_cfg     = 10'd128;
        mheight_cfg    = 10'd296;
        repeat (2)
            @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_clear_fill();
        test_directed_writes();
        test_rotation_mirror();
        test_dimension_limits();
        test_output_backpressure();
        wait_idle();

        if (error_count == 0 && expected_bytes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
